@@ sv/serial_terminal_line_interface_macros.svh @@
// Assertion macros for the serial terminal line interface.
// Included by serial_terminal_line_interface, which carries concurrent checks; needs clk and rst in scope.
`ifndef SERIAL_TERMINAL_LINE_INTERFACE_MACROS_SVH
`define SERIAL_TERMINAL_LINE_INTERFACE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define STLI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define STLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/stli_pkg.sv @@
// Shared types, constants and functions of the serial terminal line interface.
// No dependencies; used by stli_decode and serial_terminal_line_interface.
`default_nettype none

package stli_pkg;

  // Transfer kinds carried in the mode field
  localparam logic [1:0] MODE_POLL  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Register byte addresses on the 18-bit bus
  localparam logic [17:0] ADDR_RCSR = 18'o776440;
  localparam logic [17:0] ADDR_RBUF = 18'o776442;
  localparam logic [17:0] ADDR_XCSR = 18'o776444;
  localparam logic [17:0] ADDR_XBUF = 18'o776446;

  // Polls the transmitter waits past a buffer write before sending
  localparam logic [5:0] TX_DELAY   = 6'd32;
  localparam logic [5:0] WAIT_MAX   = 6'h3f;

  // Status register bit positions
  localparam int unsigned CSR_DONE_BIT = 7;
  localparam int unsigned CSR_IE_BIT   = 6;

  // Decoded access strobes for one transfer
  typedef struct packed {
    logic poll;
    logic rd_rcsr;
    logic rd_rbuf;
    logic rd_xcsr;
    logic wr_rcsr;
    logic wr_xcsr;
    logic wr_xbuf;
    logic bad;
  } stli_acc_t;

  // Character translation applied on receive
  function automatic logic [7:0] map_rx_char(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      8'd42:   m = 8'd4;
      8'd19:   m = 8'o034;
      default: m = c;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ sv/serial_terminal_line_interface.sv @@
// Top level of the serial terminal line interface: console receiver and transmitter.
// Depends on stli_pkg, stli_decode and serial_terminal_line_interface_macros.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_ready  | mode rx_valid rx_char bus_address write_data
//   out     | output    | out_valid / out_ready| read_data tx_valid tx_char rx_irq tx_irq
//           |           |                      | bad_address
//
// One transfer in, one transfer out: the input transfer is
// decoded and the register file updated in the cycle it is accepted, and the result
// lands in the output register at that same edge.
// Sustained rate is one item per cycle; in_ready holds high while the output register
// is empty or is being drained in the same cycle, so a stalled out side stalls in.
// Synchronous active-high rst clears all status, enables, buffers and the wait counter
// and sets transmitter ready; no clearing pass follows.
`default_nettype none

`include "serial_terminal_line_interface_macros.svh"

module serial_terminal_line_interface (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic        rx_valid,
  input  wire logic [7:0]  rx_char,
  input  wire logic [17:0] bus_address,
  input  wire logic [15:0] write_data,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      read_data,
  output logic             tx_valid,
  output logic [6:0]       tx_char,
  output logic             rx_irq,
  output logic             tx_irq,
  output logic             bad_address
);

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic accept;

  // Take a new item whenever the result register is free or emptying now
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Decode the transfer
  // ---------------------------------------------------------------------------
  stli_pkg::stli_acc_t acc;

  stli_decode u_decode (
    .mode        (mode),
    .bus_address (bus_address),
    .acc         (acc)
  );

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  logic       rx_done,       rx_done_next;
  logic       rx_int_enable, rx_int_enable_next;
  logic [7:0] rx_buffer,     rx_buffer_next;
  logic       tx_ready,      tx_ready_next;
  logic       tx_int_enable, tx_int_enable_next;
  logic [7:0] tx_buffer,     tx_buffer_next;
  logic [5:0] tx_wait_count, tx_wait_count_next;

  // Result of the item being accepted
  logic [15:0] read_data_next;
  logic        tx_valid_next;
  logic [6:0]  tx_char_next;
  logic        rx_irq_next;
  logic        tx_irq_next;

  logic [5:0]  wait_step;
  logic        rx_take;
  logic        tx_send;

  // Wait counter advances on each poll while a character is pending and saturates
  assign wait_step = (tx_wait_count == stli_pkg::WAIT_MAX) ? tx_wait_count
                                                           : tx_wait_count + 6'd1;
  assign rx_take   = acc.poll && rx_valid;
  assign tx_send   = acc.poll && !tx_ready && (wait_step > stli_pkg::TX_DELAY);

  always_comb begin
    rx_done_next       = rx_done;
    rx_int_enable_next = rx_int_enable;
    rx_buffer_next     = rx_buffer;
    tx_ready_next      = tx_ready;
    tx_int_enable_next = tx_int_enable;
    tx_buffer_next     = tx_buffer;
    tx_wait_count_next = tx_wait_count;

    read_data_next = '0;
    tx_valid_next  = 1'b0;
    tx_char_next   = '0;
    rx_irq_next    = 1'b0;
    tx_irq_next    = 1'b0;

    // Receiver: store the translated byte, overwrite on overrun
    if (rx_take) begin
      rx_buffer_next = stli_pkg::map_rx_char(rx_char);
      rx_done_next   = 1'b1;
      rx_irq_next    = rx_int_enable;
    end

    // Transmitter: step the wait, send once it passes the delay
    if (acc.poll && !tx_ready) begin
      tx_wait_count_next = wait_step;
    end
    if (tx_send) begin
      tx_valid_next = 1'b1;
      tx_char_next  = tx_buffer[6:0];
      tx_ready_next = 1'b1;
      tx_irq_next   = tx_int_enable;
    end

    // Bus reads
    if (acc.rd_rcsr) begin
      read_data_next[stli_pkg::CSR_DONE_BIT] = rx_done;
      read_data_next[stli_pkg::CSR_IE_BIT]   = rx_int_enable;
    end
    if (acc.rd_rbuf && rx_done) begin
      // reading the buffer acknowledges the character
      read_data_next = {8'd0, rx_buffer};
      rx_done_next   = 1'b0;
    end
    if (acc.rd_xcsr) begin
      read_data_next[stli_pkg::CSR_DONE_BIT] = tx_ready;
      read_data_next[stli_pkg::CSR_IE_BIT]   = tx_int_enable;
    end

    // Bus writes touch only the enables and the transmit buffer; a buffer write also clears ready and the wait
    if (acc.wr_rcsr) begin
      rx_int_enable_next = write_data[stli_pkg::CSR_IE_BIT];
    end
    if (acc.wr_xcsr) begin
      tx_int_enable_next = write_data[stli_pkg::CSR_IE_BIT];
    end
    if (acc.wr_xbuf) begin
      tx_buffer_next     = write_data[7:0];
      tx_ready_next      = 1'b0;
      tx_wait_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_done       <= 1'b0;
      rx_int_enable <= 1'b0;
      rx_buffer     <= '0;
      tx_ready      <= 1'b1;
      tx_int_enable <= 1'b0;
      tx_buffer     <= '0;
      tx_wait_count <= '0;
    end else if (accept) begin
      rx_done       <= rx_done_next;
      rx_int_enable <= rx_int_enable_next;
      rx_buffer     <= rx_buffer_next;
      tx_ready      <= tx_ready_next;
      tx_int_enable <= tx_int_enable_next;
      tx_buffer     <= tx_buffer_next;
      tx_wait_count <= tx_wait_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload loads only with a new transfer, so it holds while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data   <= read_data_next;
      tx_valid    <= tx_valid_next;
      tx_char     <= tx_char_next;
      rx_irq      <= rx_irq_next;
      tx_irq      <= tx_irq_next;
      bad_address <= acc.bad;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `STLI_ASSERT_NOW(a_wait_bounded, !tx_ready, tx_wait_count <= stli_pkg::TX_DELAY,
    "wait counter passed the delay with a character still pending")
  `STLI_ASSERT_NEXT(a_xbuf_clears_ready, accept && acc.wr_xbuf, !tx_ready,
    "transmit buffer write did not clear transmitter ready")
  `STLI_ASSERT_NEXT(a_rx_sets_done, accept && rx_take, rx_done,
    "received character did not set receiver done")
  `STLI_ASSERT_NOW(a_bad_is_quiet, out_valid && bad_address,
    !tx_valid && !rx_irq && !tx_irq && (read_data == 16'd0),
    "bad address result carries line activity or read data")

endmodule

`default_nettype wire

@@ sv/stli_decode.sv @@
// Address and mode decoder of the serial terminal line interface.
// Depends on stli_pkg for mode codes, register addresses and stli_acc_t.
`default_nettype none

module stli_decode (
  input  wire logic [1:0]       mode,
  input  wire logic [17:0]      bus_address,
  output stli_pkg::stli_acc_t   acc
);

  logic hit_rcsr, hit_rbuf, hit_xcsr, hit_xbuf, hit_any;

  assign hit_rcsr = (bus_address == stli_pkg::ADDR_RCSR);
  assign hit_rbuf = (bus_address == stli_pkg::ADDR_RBUF);
  assign hit_xcsr = (bus_address == stli_pkg::ADDR_XCSR);
  assign hit_xbuf = (bus_address == stli_pkg::ADDR_XBUF);
  assign hit_any  = hit_rcsr | hit_rbuf | hit_xcsr | hit_xbuf;

  always_comb begin
    acc = '0;
    unique case (mode)
      stli_pkg::MODE_POLL: begin
        acc.poll = 1'b1;
      end
      stli_pkg::MODE_READ: begin
        acc.rd_rcsr = hit_rcsr;
        acc.rd_rbuf = hit_rbuf;
        acc.rd_xcsr = hit_xcsr;
        acc.bad     = !hit_any;
      end
      stli_pkg::MODE_WRITE: begin
        // receive buffer writes drop silently
        acc.wr_rcsr = hit_rcsr;
        acc.wr_xcsr = hit_xcsr;
        acc.wr_xbuf = hit_xbuf;
        acc.bad     = !hit_any;
      end
      default: begin
        acc = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
